[sv/i2cmbe_pkg.sv]
// Shared types, constants and a helper function for the I2C master bit engine.
package i2cmbe_pkg;

  localparam int unsigned TickW   = 16;
  localparam int unsigned PhaseW  = 5;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned InDataW = 16;
  localparam int unsigned OutDataW = 16;

  localparam logic [TickW-1:0] PhaseTicksReset = 16'd201;

  // Write commands drive eight bits of three phases each before the ACK slot.
  localparam logic [PhaseW-1:0] WriteAckPhase = 5'd24;
  localparam logic [PhaseW-1:0] WriteRelPhase = 5'd24;
  localparam logic [PhaseW-1:0] WriteSclPhase = 5'd25;
  localparam logic [PhaseW-1:0] WriteSmpPhase = 5'd26;

  typedef enum logic [ReqW-1:0] {
    REQ_TICK  = 3'd0,
    REQ_START = 3'd1,
    REQ_STOP  = 3'd2,
    REQ_WRITE = 3'd3,
    REQ_READ  = 3'd4,
    REQ_ACK   = 3'd5
  } req_t;

  typedef enum logic [ReqW-1:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4,
    CMD_ACK   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_CMD  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REM_0 = 2'd0,
    REM_1 = 2'd1,
    REM_2 = 2'd2
  } rem_t;

  typedef struct packed {
    kind_t            kind;
    cmd_t             cmd;
    logic [ByteW-1:0] tx_byte;
    logic             sda_in;
  } item_t;

  typedef struct packed {
    logic             cmd_rejected;
    logic [ByteW-1:0] rx_byte;
    logic             nack_seen;
    logic             done_res;
    logic             busy_res;
    logic             sda_released;
    logic             sda_level;
    logic             scl_level;
  } result_t;

  // Number of phases in each command.
  function automatic logic [PhaseW-1:0] phase_total(input cmd_t cmd);
    logic [PhaseW-1:0] n;
    case (cmd)
      CMD_START: n = 5'd4;
      CMD_STOP:  n = 5'd4;
      CMD_WRITE: n = 5'd28;
      CMD_READ:  n = 5'd24;
      CMD_ACK:   n = 5'd3;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

[sv/i2c_master_bit_engine_unit.sv]
// Top level of the I2C master bit engine: front end, item queue and sequencer.
// A result beat passes through the queue and then the sequencer's result
// register before it is presented.
// Throughput: one beat per cycle while the result channel is not stalled, set by the sequencer update.
// Reset (rst_n low, synchronous): engine idle, SCL and SDA driven high, flags
// and read byte cleared, queue and result register empty, phase_ticks 201.
module i2c_master_bit_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // [7:0] tx_byte, [8] sda_in, [15:9] zero
  input  logic [2:0]  in_tuser,  // [2:0] req_type
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_released, [3] busy_res, [4] done_res,
  // [5] nack_seen, [13:6] rx_byte, [14] cmd_rejected, [15] zero
  output logic [15:0] out_tdata,
  // Configuration: phase_ticks.
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  // The phase length register. Software must write it only while the engine is
  // quiet; the block itself does not enforce this. It feeds the sequencer directly.
  logic [i2cmbe_pkg::TickW-1:0] phase_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cmbe_pkg::PhaseTicksReset;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  logic                q_push;
  logic                q_not_full;
  logic                q_pop;
  logic                q_not_empty;
  i2cmbe_pkg::item_t   q_in_item;
  i2cmbe_pkg::item_t   q_out_item;
  i2cmbe_pkg::result_t res;

  // The front end decodes the request code into a command, a tick or an empty item.
  i2cmbe_front u_front (
    .in_valid (in_tvalid),
    .req_type (in_tuser),
    .tx_byte  (in_tdata[7:0]),
    .sda_in   (in_tdata[8]),
    .q_ready  (q_not_full),
    .in_ready (in_tready),
    .q_push   (q_push),
    .q_item   (q_in_item)
  );

  // The queue lets the front keep taking beats while a result waits.
  i2cmbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (q_out_item)
  );

  // The sequencer applies one item per cycle whenever its result slot frees.
  i2cmbe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .q_not_empty (q_not_empty),
    .q_item      (q_out_item),
    .q_pop       (q_pop),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  assign out_tdata = {1'b0, res};

endmodule

[sv/i2cmbe_front.sv]
// Front end: takes input beats and classifies each request before queueing it.
module i2cmbe_front (
  input  logic                          in_valid,
  input  logic [i2cmbe_pkg::ReqW-1:0]   req_type,
  input  logic [i2cmbe_pkg::ByteW-1:0]  tx_byte,
  input  logic                          sda_in,
  input  logic                          q_ready,
  output logic                          in_ready,
  output logic                          q_push,
  output i2cmbe_pkg::item_t             q_item
);

  always_comb begin
    q_item.tx_byte = tx_byte;
    q_item.sda_in  = sda_in;
    q_item.cmd     = i2cmbe_pkg::CMD_IDLE;
    case (req_type)
      i2cmbe_pkg::REQ_TICK: begin
        q_item.kind = i2cmbe_pkg::KIND_TICK;
      end
      i2cmbe_pkg::REQ_START: begin
        q_item.kind = i2cmbe_pkg::KIND_CMD;
        q_item.cmd  = i2cmbe_pkg::CMD_START;
      end
      i2cmbe_pkg::REQ_STOP: begin
        q_item.kind = i2cmbe_pkg::KIND_CMD;
        q_item.cmd  = i2cmbe_pkg::CMD_STOP;
      end
      i2cmbe_pkg::REQ_WRITE: begin
        q_item.kind = i2cmbe_pkg::KIND_CMD;
        q_item.cmd  = i2cmbe_pkg::CMD_WRITE;
      end
      i2cmbe_pkg::REQ_READ: begin
        q_item.kind = i2cmbe_pkg::KIND_CMD;
        q_item.cmd  = i2cmbe_pkg::CMD_READ;
      end
      i2cmbe_pkg::REQ_ACK: begin
        q_item.kind = i2cmbe_pkg::KIND_CMD;
        q_item.cmd  = i2cmbe_pkg::CMD_ACK;
      end
      default: begin
        // Unused request codes still produce a result but change nothing.
        q_item.kind = i2cmbe_pkg::KIND_NONE;
      end
    endcase
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

endmodule

[sv/i2cmbe_queue.sv]
// Two-entry queue of classified items between the front and back ends.
module i2cmbe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  i2cmbe_pkg::item_t push_item,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output i2cmbe_pkg::item_t pop_item
);

  i2cmbe_pkg::item_t slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[sv/i2cmbe_back.sv]
// Back end: runs the SCL/SDA phase sequencer and holds the result register.
module i2cmbe_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [i2cmbe_pkg::TickW-1:0]  phase_ticks,
  input  logic                          q_not_empty,
  input  i2cmbe_pkg::item_t             q_item,
  output logic                          q_pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output i2cmbe_pkg::result_t           res
);

  i2cmbe_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [i2cmbe_pkg::PhaseW-1:0]    ph_r, ph_nxt;
  i2cmbe_pkg::rem_t                 rem_r, rem_nxt;
  logic [i2cmbe_pkg::TickW-1:0]     tick_r, tick_nxt;
  logic [i2cmbe_pkg::ByteW-1:0]     sb_r, sb_nxt;
  logic                             ack_r, ack_nxt;
  logic                             scl_r, scl_nxt;
  logic                             sda_r, sda_nxt;
  logic                             rel_r, rel_nxt;
  logic [i2cmbe_pkg::ByteW-1:0]     rx_r, rx_nxt;
  logic                             vld_r, vld_nxt;
  i2cmbe_pkg::result_t              res_r, res_nxt;

  logic                             done;
  logic                             rejected;
  logic                             act_en;
  i2cmbe_pkg::cmd_t                 act_cmd;
  logic [i2cmbe_pkg::PhaseW-1:0]    act_ph;
  i2cmbe_pkg::rem_t                 act_rem;
  logic [i2cmbe_pkg::TickW:0]       cnt_sum;
  logic [i2cmbe_pkg::TickW:0]       limit;
  logic [i2cmbe_pkg::PhaseW-1:0]    ph_inc;
  i2cmbe_pkg::rem_t                 rem_inc;

  assign q_pop     = q_not_empty & (~vld_r | res_ready);
  assign res_valid = vld_r;
  assign res       = res_r;

  always_comb begin
    cmd_nxt  = cmd_r;
    ph_nxt   = ph_r;
    rem_nxt  = rem_r;
    tick_nxt = tick_r;
    sb_nxt   = sb_r;
    ack_nxt  = ack_r;
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    rel_nxt  = rel_r;
    rx_nxt   = rx_r;
    done     = 1'b0;
    rejected = 1'b0;
    act_en   = 1'b0;
    act_cmd  = cmd_r;
    act_ph   = ph_r;
    act_rem  = rem_r;
    limit    = {1'b0, (phase_ticks == '0) ? 16'd1 : phase_ticks};
    cnt_sum  = {1'b0, tick_r} + 17'd1;
    ph_inc   = ph_r + 5'd1;
    rem_inc  = (rem_r == i2cmbe_pkg::REM_2) ? i2cmbe_pkg::REM_0 :
               ((rem_r == i2cmbe_pkg::REM_0) ? i2cmbe_pkg::REM_1 : i2cmbe_pkg::REM_2);

    if (q_pop) begin
      case (q_item.kind)
        i2cmbe_pkg::KIND_TICK: begin
          if (cmd_r != i2cmbe_pkg::CMD_IDLE) begin
            if (cnt_sum >= limit) begin
              tick_nxt = '0;
              if (ph_inc >= i2cmbe_pkg::phase_total(cmd_r)) begin
                if (cmd_r == i2cmbe_pkg::CMD_READ) begin
                  rx_nxt = sb_r;
                end
                cmd_nxt = i2cmbe_pkg::CMD_IDLE;
                ph_nxt  = '0;
                rem_nxt = i2cmbe_pkg::REM_0;
                done    = 1'b1;
              end else begin
                ph_nxt  = ph_inc;
                rem_nxt = rem_inc;
                act_en  = 1'b1;
                act_ph  = ph_inc;
                act_rem = rem_inc;
              end
            end else begin
              tick_nxt = cnt_sum[i2cmbe_pkg::TickW-1:0];
            end
          end
        end
        i2cmbe_pkg::KIND_CMD: begin
          if (cmd_r != i2cmbe_pkg::CMD_IDLE) begin
            rejected = 1'b1;
          end else begin
            cmd_nxt  = q_item.cmd;
            ph_nxt   = '0;
            rem_nxt  = i2cmbe_pkg::REM_0;
            tick_nxt = '0;
            if (q_item.cmd == i2cmbe_pkg::CMD_WRITE) begin
              sb_nxt  = q_item.tx_byte;
              ack_nxt = 1'b0;
            end else if (q_item.cmd == i2cmbe_pkg::CMD_READ) begin
              sb_nxt = '0;
            end
            act_en  = 1'b1;
            act_cmd = q_item.cmd;
            act_ph  = '0;
            act_rem = i2cmbe_pkg::REM_0;
          end
        end
        default: begin
        end
      endcase
    end

    // Pin action of the phase being entered.
    if (act_en) begin
      case (act_cmd)
        i2cmbe_pkg::CMD_START, i2cmbe_pkg::CMD_STOP: begin
          if (act_ph == 5'd0) begin
            rel_nxt = 1'b0;
            sda_nxt = (act_cmd == i2cmbe_pkg::CMD_START);
          end else if (act_ph == 5'd1) begin
            scl_nxt = 1'b1;
          end else if (act_ph == 5'd2) begin
            sda_nxt = (act_cmd != i2cmbe_pkg::CMD_START);
          end else begin
            scl_nxt = 1'b0;
          end
        end
        i2cmbe_pkg::CMD_WRITE: begin
          if (act_ph < i2cmbe_pkg::WriteAckPhase) begin
            if (act_rem == i2cmbe_pkg::REM_0) begin
              // Bits leave from the top; the shifter moves up one per bit.
              rel_nxt = 1'b0;
              sda_nxt = sb_nxt[i2cmbe_pkg::ByteW-1];
              sb_nxt  = {sb_nxt[i2cmbe_pkg::ByteW-2:0], 1'b0};
            end else if (act_rem == i2cmbe_pkg::REM_1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
            end
          end else if (act_ph == i2cmbe_pkg::WriteRelPhase) begin
            rel_nxt = 1'b1;
          end else if (act_ph == i2cmbe_pkg::WriteSclPhase) begin
            scl_nxt = 1'b1;
          end else if (act_ph == i2cmbe_pkg::WriteSmpPhase) begin
            ack_nxt = q_item.sda_in;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        i2cmbe_pkg::CMD_READ: begin
          if (act_rem == i2cmbe_pkg::REM_0) begin
            rel_nxt = 1'b1;
            scl_nxt = 1'b1;
          end else if (act_rem == i2cmbe_pkg::REM_1) begin
            sb_nxt = {sb_nxt[i2cmbe_pkg::ByteW-2:0], q_item.sda_in};
          end else begin
            scl_nxt = 1'b0;
          end
        end
        i2cmbe_pkg::CMD_ACK: begin
          if (act_ph == 5'd0) begin
            rel_nxt = 1'b0;
            sda_nxt = 1'b0;
          end else if (act_ph == 5'd1) begin
            scl_nxt = 1'b1;
          end else begin
            scl_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    res_nxt.scl_level    = scl_nxt;
    res_nxt.sda_level    = sda_nxt;
    res_nxt.sda_released = rel_nxt;
    res_nxt.busy_res     = (cmd_nxt != i2cmbe_pkg::CMD_IDLE);
    res_nxt.done_res     = done;
    res_nxt.nack_seen    = ack_nxt;
    res_nxt.rx_byte      = rx_nxt;
    res_nxt.cmd_rejected = rejected;

    vld_nxt = q_pop | (vld_r & ~res_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= i2cmbe_pkg::CMD_IDLE;
      ph_r   <= '0;
      rem_r  <= i2cmbe_pkg::REM_0;
      tick_r <= '0;
      sb_r   <= '0;
      ack_r  <= 1'b0;
      scl_r  <= 1'b1;
      sda_r  <= 1'b1;
      rel_r  <= 1'b0;
      rx_r   <= '0;
      vld_r  <= 1'b0;
    end else begin
      cmd_r  <= cmd_nxt;
      ph_r   <= ph_nxt;
      rem_r  <= rem_nxt;
      tick_r <= tick_nxt;
      sb_r   <= sb_nxt;
      ack_r  <= ack_nxt;
      scl_r  <= scl_nxt;
      sda_r  <= sda_nxt;
      rel_r  <= rel_nxt;
      rx_r   <= rx_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

[sv/i2cmbe_checker.sv]
// Port-level checks for the I2C master bit engine, bound to the top level.
module i2cmbe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // A finished command is never reported as still running.
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> !out_tdata[3])
    else $error("done reported while busy");

  // A command is only dropped while another one runs.
  a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14] |-> out_tdata[3])
    else $error("command rejected while idle");

  // No result beat straight out of reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result beat holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_i2cmbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata)
);

[dv/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master bit engine: stream stimulus, scoreboard, checks.
module tb;
  import i2cmbe_pkg::*;

  // Request codes six and seven have no meaning; the engine must leave them alone.
  localparam logic [ReqW-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [ReqW-1:0] REQ_SPARE_HI = 3'd7;

  // Each data bit of a write or a read takes three phases.
  localparam int unsigned PhasesPerBit = 3;

  // The bound is meant to trip only on a hung handshake.
  localparam int unsigned CycleLimit = 400000;

  // Cycles allowed for the queue and the result register to empty.
  localparam int unsigned DrainCycles = 4;

  // The scoreboard carries its own copy of the engine state. Every request
  // beat that is taken produces exactly one result beat, so each accepted
  // request pushes one predicted result, and each result beat is checked
  // against the oldest prediction.
  class i2c_engine_scoreboard;
    cmd_t             cmd;
    int unsigned      phase;
    int unsigned      ticks;
    logic [ByteW-1:0] shreg;
    logic [ByteW-1:0] rx_hold;
    logic             ack_bit;
    logic             scl;
    logic             sda_out;
    logic             rel;
    logic [TickW-1:0] period;
    result_t          expected_q[$];
    int unsigned      errors;

    function new();
      cmd       = CMD_IDLE;
      phase     = 0;
      ticks     = 0;
      shreg     = '0;
      rx_hold   = '0;
      ack_bit   = 1'b0;
      scl       = 1'b1;
      sda_out   = 1'b1;
      rel       = 1'b0;
      period    = PhaseTicksReset;
      errors    = 0;
    endfunction

    function void set_period(logic [TickW-1:0] value);
      period = value;
    endfunction

    function bit busy();
      return cmd != CMD_IDLE;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function int unsigned phases_of(cmd_t c);
      case (c)
        CMD_START: return 4;
        CMD_STOP:  return 4;
        CMD_WRITE: return 28;
        CMD_READ:  return 24;
        CMD_ACK:   return 3;
        default:   return 0;
      endcase
    endfunction

    // Pin action taken on entry to a phase. The ACK sample and the read
    // samples use the SDA pin level carried by the beat that ends the hold.
    function void apply_action(int unsigned ph, logic sda_pin);
      int unsigned bit_no;
      int unsigned slot;
      logic        lead;
      bit_no = ph / PhasesPerBit;
      slot   = ph % PhasesPerBit;
      lead   = (cmd == CMD_START);
      case (cmd)
        CMD_START, CMD_STOP: begin
          if (ph == 0) begin
            rel     = 1'b0;
            sda_out = lead;
          end else if (ph == 1) begin
            scl = 1'b1;
          end else if (ph == 2) begin
            sda_out = !lead;
          end else begin
            scl = 1'b0;
          end
        end
        CMD_WRITE: begin
          if (ph < WriteRelPhase) begin
            if (slot == 0) begin
              rel     = 1'b0;
              sda_out = shreg[7 - bit_no];
            end else if (slot == 1) begin
              scl = 1'b1;
            end else begin
              scl = 1'b0;
            end
          end else if (ph == WriteRelPhase) begin
            rel = 1'b1;
          end else if (ph == WriteSclPhase) begin
            scl = 1'b1;
          end else if (ph == WriteSmpPhase) begin
            ack_bit = sda_pin;
          end else begin
            scl = 1'b0;
          end
        end
        CMD_READ: begin
          if (slot == 0) begin
            rel = 1'b1;
            scl = 1'b1;
          end else if (slot == 1) begin
            shreg = {shreg[ByteW-2:0], sda_pin};
          end else begin
            scl = 1'b0;
          end
        end
        CMD_ACK: begin
          if (ph == 0) begin
            rel     = 1'b0;
            sda_out = 1'b0;
          end else if (ph == 1) begin
            scl = 1'b1;
          end else begin
            scl = 1'b0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    // Advance the engine copy by one accepted request beat and queue the
    // result that the block must return for it.
    function void note_request(logic [ReqW-1:0] req, logic [ByteW-1:0] tx, logic sda_pin);
      result_t     r;
      logic        done;
      logic        rejected;
      int unsigned lim;
      done     = 1'b0;
      rejected = 1'b0;
      lim      = (period == 0) ? 1 : period;
      if (req == REQ_TICK) begin
        if (cmd != CMD_IDLE) begin
          ticks++;
          if (ticks >= lim) begin
            ticks = 0;
            phase++;
            if (phase >= phases_of(cmd)) begin
              if (cmd == CMD_READ) rx_hold = shreg;
              cmd   = CMD_IDLE;
              phase = 0;
              done  = 1'b1;
            end else begin
              apply_action(phase, sda_pin);
            end
          end
        end
      end else if (req <= REQ_ACK) begin
        if (cmd != CMD_IDLE) begin
          rejected = 1'b1;
        end else begin
          cmd   = cmd_t'(req);
          phase = 0;
          ticks = 0;
          if (cmd == CMD_WRITE) begin
            shreg   = tx;
            ack_bit = 1'b0;
          end else if (cmd == CMD_READ) begin
            shreg = '0;
          end
          apply_action(0, sda_pin);
        end
      end
      r.scl_level    = scl;
      r.sda_level    = sda_out;
      r.sda_released = rel;
      r.busy_res     = (cmd != CMD_IDLE);
      r.done_res     = done;
      r.nack_seen    = ack_bit;
      r.rx_byte      = rx_hold;
      r.cmd_rejected = rejected;
      expected_q.push_back(r);
    endfunction

    function int unsigned field_differs(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v == act_v) return 0;
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      return 1;
    endfunction

    function void check_result(logic [OutDataW-1:0] beat);
      result_t got;
      result_t exp_r;
      got = result_t'(beat[14:0]);
      if (expected_q.size() == 0) begin
        $error("result beat %h arrived with nothing expected", beat);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      errors += field_differs("scl_level", exp_r.scl_level, got.scl_level);
      errors += field_differs("sda_level", exp_r.sda_level, got.sda_level);
      errors += field_differs("sda_released", exp_r.sda_released, got.sda_released);
      errors += field_differs("busy_res", exp_r.busy_res, got.busy_res);
      errors += field_differs("done_res", exp_r.done_res, got.done_res);
      errors += field_differs("nack_seen", exp_r.nack_seen, got.nack_seen);
      errors += field_differs("rx_byte", exp_r.rx_byte, got.rx_byte);
      errors += field_differs("cmd_rejected", exp_r.cmd_rejected, got.cmd_rejected);
      errors += field_differs("pad", 0, beat[15]);
    endfunction
  endclass

  // Every input of the block has a known value from time zero.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [ReqW-1:0]     in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_wr_en = 1'b0;
  logic [TickW-1:0]    cfg_wr_data = '0;

  i2c_engine_scoreboard sb = new();

  int unsigned send_idle_pct = 38;
  int unsigned recv_idle_pct = 59;
  int unsigned cycle_count = 0;

  // How the SDA pin behaves for the command in flight: held low, held high,
  // or random on every beat. Held levels give all-zero and all-one reads as
  // well as forced ACK and NACK after a write.
  int unsigned sda_style = 2;

  i2c_master_bit_engine_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [7:0] tx_byte, [8] sda_in, [15:9] zero
    .in_tuser    (in_tuser),     // [2:0] req_type
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    // [0] scl_level, [1] sda_level, [2] sda_released, [3] busy_res,
    // [4] done_res, [5] nack_seen, [13:6] rx_byte, [14] cmd_rejected, [15] zero
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver stalls at random; its ready changes only on the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result beats are sampled at the rising edge, before the block's own
  // updates for that edge take effect.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one request beat, with random gaps ahead of it, and hold it until
  // it is taken. Called and left on a falling edge, so a back-to-back beat
  // keeps tvalid high without it being lowered in between.
  task automatic send_request(logic [ReqW-1:0] req, logic [ByteW-1:0] tx, logic sda_pin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'd0, sda_pin, tx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(req, tx, sda_pin);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has been returned,
  // then let the pipeline settle.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // The register is only written with the pipeline empty.
  task automatic write_phase_ticks(logic [TickW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_period(value);
  endtask

  function automatic logic pick_sda();
    if (sda_style == 0) return 1'b0;
    if (sda_style == 1) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  // Mostly well-formed traffic: a command while the engine is idle, then
  // ticks until it is done. Commands sent while busy, ticks while idle and the
  // spare request codes are mixed in as noise.
  task automatic pick_request(output logic [ReqW-1:0] req, output logic [ByteW-1:0] tx,
                              output logic sda_pin);
    int unsigned roll;
    int unsigned which;
    roll  = $urandom_range(99);
    which = $urandom_range(99);
    req   = REQ_TICK;
    tx    = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) tx = 8'h00;
    else if ($urandom_range(9) == 0) tx = 8'hFF;
    if (!sb.busy()) begin
      if (roll < 8) begin
        req = REQ_TICK;
      end else if (roll < 13) begin
        req = (which < 50) ? REQ_SPARE_LO : REQ_SPARE_HI;
      end else begin
        if (which < 15) req = REQ_START;
        else if (which < 30) req = REQ_STOP;
        else if (which < 60) req = REQ_WRITE;
        else if (which < 85) req = REQ_READ;
        else req = REQ_ACK;
        sda_style = $urandom_range(3);
        if (sda_style > 2) sda_style = 2;
      end
    end else begin
      if (roll < 93) begin
        req = REQ_TICK;
      end else if (roll < 97) begin
        req = 3'($urandom_range(REQ_ACK, REQ_START));
      end else begin
        req = (which < 50) ? REQ_SPARE_LO : REQ_SPARE_HI;
      end
    end
    sda_pin = pick_sda();
  endtask

  initial begin
    int unsigned      cfg_plan[7];
    int unsigned      beats_plan[7];
    int unsigned      mode_plan[7];
    logic [ReqW-1:0]  req;
    logic [ByteW-1:0] tx;
    logic             sda_pin;

    // Phases of the random part: register value, number of request beats and
    // idling mode (0 sender light, receiver heavy; 1 the other way round;
    // 2 no idling). Zero must behave as one tick per phase, and the largest
    // value leaves a command hanging across the next register write.
    cfg_plan   = '{0, 2, 65535, 3, 0, 1, 0};
    beats_plan = '{350, 250, 60, 300, 250, 400, 240};
    mode_plan  = '{0, 0, 1, 1, 1, 2, 2};
    cfg_plan[4] = $urandom_range(8, 1);
    cfg_plan[6] = $urandom_range(4, 1);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening at the reset setting of 201 ticks per phase: a tick
    // while idle, the spare codes, a start, then every other command while busy
    // (each must be dropped) and a spare code while busy.
    send_request(REQ_TICK, 8'h00, 1'b0);
    send_request(REQ_SPARE_LO, 8'hFF, 1'b1);
    send_request(REQ_SPARE_HI, 8'h00, 1'b0);
    send_request(REQ_START, 8'h5A, 1'b1);
    send_request(REQ_STOP, 8'h00, 1'b0);
    send_request(REQ_WRITE, 8'hFF, 1'b1);
    send_request(REQ_READ, 8'h00, 1'b0);
    send_request(REQ_ACK, 8'hFF, 1'b1);
    send_request(REQ_SPARE_HI, 8'hFF, 1'b1);
    repeat (3) send_request(REQ_TICK, 8'h00, 1'b1);

    // Drop to one tick per phase: the half-held start now finishes quickly,
    // then a stop and a master ACK run to completion.
    drain_results();
    write_phase_ticks(16'd1);
    repeat (4) send_request(REQ_TICK, 8'hFF, 1'b0);
    send_request(REQ_STOP, 8'h00, 1'b1);
    repeat (4) send_request(REQ_TICK, 8'h00, 1'b1);
    send_request(REQ_ACK, 8'hFF, 1'b0);
    repeat (3) send_request(REQ_TICK, 8'h00, 1'b0);

    for (int p = 0; p < 7; p++) begin
      case (mode_plan[p])
        0: begin
          send_idle_pct = 38;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 38;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      drain_results();
      write_phase_ticks(16'(cfg_plan[p]));
      for (int i = 0; i < beats_plan[p]; i++) begin
        // Once, half way through a phase, hold back until every result is in.
        if (p == 1 && i == beats_plan[p] / 2) drain_results();
        pick_request(req, tx, sda_pin);
        send_request(req, tx, sda_pin);
      end
    end

    drain_results();
    repeat (8) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
